[rtl/core/sleep_alarm_arbiter_top_defines.svh]
// Assertion macros used by the sleep alarm arbiter core.
`ifndef SLEEP_ALARM_ARBITER_TOP_DEFINES_SVH
`define SLEEP_ALARM_ARBITER_TOP_DEFINES_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define SA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define SA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sa_arb_pkg.sv]
// Types, constants and register map of the sleep alarm arbiter.
package sa_arb_pkg;

    localparam int unsigned REFIRE_GUARD_S = 60;

    localparam logic [11:0] HZ_HIGH     = 12'd2400;
    localparam logic [11:0] HZ_LOW      = 12'd1800;
    localparam logic [31:0] DUR_HIGH_MS = 32'd4000;
    localparam logic [31:0] DUR_LOW_MS  = 32'd3000;
    localparam logic [15:0] SPO2_NONE   = 16'hFFFF;
    localparam logic [9:0]  MS_PER_S    = 10'd1000;

    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned ADDR_W     = 5;

    typedef enum logic [2:0] {
        REG_ALARM_EN   = 3'd0,
        REG_DAY_MASK   = 3'd1,
        REG_WIN_START  = 3'd2,
        REG_WIN_END    = 3'd3,
        REG_SPO2_LIMIT = 3'd4,
        REG_SPO2_SUST  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        FIRE_NONE  = 2'd0,
        FIRE_SMART = 2'd1,
        FIRE_SPO2  = 2'd2
    } fire_t;

    typedef struct packed {
        logic        alarm_enable;
        logic [6:0]  day_mask;
        logic [10:0] window_start_min;
        logic [10:0] window_end_min;
        logic [9:0]  spo2_low_limit;
        logic [11:0] spo2_sustain_s;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [31:0] epoch_s;
        logic [2:0]  week_day;
        logic [10:0] minute_of_day;
        logic        session_active;
        logic        light_or_awake;
        logic [15:0] spo2_tenths;
        logic        motion_flag;
        logic        no_finger;
    } tick_t;

    typedef struct packed {
        logic        buzzer_on;
        logic [11:0] tone_hz;
        logic [1:0]  fire_event;
    } result_t;

endpackage

[rtl/core/sa_arb_cfg.sv]
// APB register file holding the alarm window and SpO2 settings.
module sa_arb_cfg
    import sa_arb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_ALARM_EN:   cfg_next.alarm_enable     = pwdata[0];
                REG_DAY_MASK:   cfg_next.day_mask         = pwdata[6:0];
                REG_WIN_START:  cfg_next.window_start_min = pwdata[10:0];
                REG_WIN_END:    cfg_next.window_end_min   = pwdata[10:0];
                REG_SPO2_LIMIT: cfg_next.spo2_low_limit   = pwdata[9:0];
                REG_SPO2_SUST:  cfg_next.spo2_sustain_s   = pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ALARM_EN:   prdata = {31'd0, cfg_reg.alarm_enable};
            REG_DAY_MASK:   prdata = {25'd0, cfg_reg.day_mask};
            REG_WIN_START:  prdata = {21'd0, cfg_reg.window_start_min};
            REG_WIN_END:    prdata = {21'd0, cfg_reg.window_end_min};
            REG_SPO2_LIMIT: prdata = {22'd0, cfg_reg.spo2_low_limit};
            REG_SPO2_SUST:  prdata = {20'd0, cfg_reg.spo2_sustain_s};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_enable     <= 1'b0;
            cfg_reg.day_mask         <= 7'd0;
            cfg_reg.window_start_min <= 11'd390;
            cfg_reg.window_end_min   <= 11'd420;
            cfg_reg.spo2_low_limit   <= 10'd900;
            cfg_reg.spo2_sustain_s   <= 12'd30;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/sa_arb_core.sv]
// Alarm decision logic and the tone, refire and breach state it keeps.
`include "sleep_alarm_arbiter_top_defines.svh"

module sa_arb_core
    import sa_arb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  cfg_t    cfg,
    input  tick_t   tick,
    output result_t result
);

    logic        tone_active_reg, tone_active_next;
    logic [31:0] tone_end_ms_reg, tone_end_ms_next;
    logic        tone_is_high_reg, tone_is_high_next;
    logic [31:0] last_fire_epoch_reg, last_fire_epoch_next;
    logic        breach_valid_reg, breach_valid_next;
    logic [31:0] breach_start_ms_reg, breach_start_ms_next;

    logic [31:0] tone_left;
    logic        tone_still;
    logic [7:0]  mask_ext;
    logic        day_ok;
    logic [31:0] since_fire;
    logic        guard_ok;
    logic        smart_fire;
    logic        breach_cond;
    logic [31:0] start_eff;
    logic [31:0] elapsed;
    logic [21:0] sustain_ms;
    logic        low_fire;
    fire_t       event_code;

    // A tone keeps sounding while now is still behind its end time (signed compare).
    assign tone_left  = tick.now_ms - tone_end_ms_reg;
    assign tone_still = tone_active_reg && tone_left[31];

    // Weekday 7 reads the padding bit, so only an all-zero mask allows it.
    assign mask_ext = {1'b0, cfg.day_mask};
    assign day_ok   = (cfg.day_mask == 7'd0) || mask_ext[tick.week_day];

    assign since_fire = tick.epoch_s - last_fire_epoch_reg;
    assign guard_ok   = since_fire > 32'(REFIRE_GUARD_S);

    assign smart_fire = tick.session_active && cfg.alarm_enable && (tick.epoch_s != 32'd0)
                     && day_ok && (tick.minute_of_day >= cfg.window_start_min)
                     && (tick.minute_of_day < cfg.window_end_min)
                     && guard_ok && tick.light_or_awake;

    assign breach_cond = (tick.spo2_tenths != SPO2_NONE)
                      && (tick.spo2_tenths < {6'd0, cfg.spo2_low_limit})
                      && !tick.motion_flag && !tick.no_finger;

    assign start_eff  = breach_valid_reg ? breach_start_ms_reg : tick.now_ms;
    assign elapsed    = tick.now_ms - start_eff;
    assign sustain_ms = 22'(cfg.spo2_sustain_s) * 22'(MS_PER_S);

    // A smart fire wins over an SpO2 fire in the same tick; both move the last fire epoch to now.
    assign low_fire = breach_cond && (elapsed >= {10'd0, sustain_ms}) && guard_ok
                   && !smart_fire;

    always_comb begin
        tone_active_next     = tone_still;
        tone_end_ms_next     = tone_end_ms_reg;
        tone_is_high_next    = tone_is_high_reg;
        last_fire_epoch_next = last_fire_epoch_reg;
        breach_valid_next    = breach_cond;
        breach_start_ms_next = breach_start_ms_reg;
        event_code           = FIRE_NONE;
        if (breach_cond && !breach_valid_reg) begin
            breach_start_ms_next = tick.now_ms;
        end
        if (smart_fire) begin
            tone_active_next     = 1'b1;
            tone_is_high_next    = 1'b1;
            tone_end_ms_next     = tick.now_ms + DUR_HIGH_MS;
            last_fire_epoch_next = tick.epoch_s;
            event_code           = FIRE_SMART;
        end else if (low_fire) begin
            tone_active_next     = 1'b1;
            tone_is_high_next    = 1'b0;
            tone_end_ms_next     = tick.now_ms + DUR_LOW_MS;
            last_fire_epoch_next = tick.epoch_s;
            event_code           = FIRE_SPO2;
        end
    end

    assign result.buzzer_on  = tone_active_next;
    assign result.tone_hz    = tone_active_next ? (tone_is_high_next ? HZ_HIGH : HZ_LOW)
                                                : 12'd0;
    assign result.fire_event = event_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_active_reg     <= 1'b0;
            tone_end_ms_reg     <= 32'd0;
            tone_is_high_reg    <= 1'b0;
            last_fire_epoch_reg <= 32'd0;
            breach_valid_reg    <= 1'b0;
            breach_start_ms_reg <= 32'd0;
        end else if (step_en) begin
            tone_active_reg     <= tone_active_next;
            tone_end_ms_reg     <= tone_end_ms_next;
            tone_is_high_reg    <= tone_is_high_next;
            last_fire_epoch_reg <= last_fire_epoch_next;
            breach_valid_reg    <= breach_valid_next;
            breach_start_ms_reg <= breach_start_ms_next;
        end
    end

    `SA_ASSERT_IMP(a_one_alarm, step_en, !(smart_fire && low_fire), "two alarms fired in one tick")
    `SA_ASSERT_NXT(a_smart_tone, step_en && smart_fire, tone_active_reg && tone_is_high_reg,
        "smart alarm did not start the high tone")
    `SA_ASSERT_NXT(a_low_tone, step_en && low_fire, tone_active_reg && !tone_is_high_reg,
        "SpO2 alarm did not start the low tone")
    `SA_ASSERT_NXT(a_epoch_hold, !(step_en && (smart_fire || low_fire)),
        $stable(last_fire_epoch_reg), "last fire epoch moved without a fire")

endmodule

[rtl/core/sleep_alarm_arbiter_top.sv]
// Sleep alarm arbiter: tick stream in, buzzer status stream out, APB settings.
//
// The s_axis channel carries one tick word per cycle at most; the m_axis channel
// returns exactly one status word per tick, in order. The APB port holds six
// settings registers at byte addresses 0, 4, ... 20 and answers with no wait state.
// An accepted tick is captured in an input register; when the output register is
// empty or being taken, the decision logic updates the tone, refire and breach
// state and loads the output register. Throughput is one tick per cycle while
// m_axis_tready stays high; the state update of one tick is seen by the tick behind it.
// When the receiver holds m_axis_tready low, the output register and then the
// input register hold their words and s_axis_tready drops; nothing is lost.
// A synchronous active-low reset empties both registers, silences the tone,
// drops any running SpO2 breach and restores the settings to their reset values.
// Settings are to be written only while no tick is in flight.
module sleep_alarm_arbiter_top
    import sa_arb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_ms[31:0], epoch_s[63:32], week_day[66:64], minute_of_day[77:67],
    // session_active[78], light_or_awake[79], spo2_tenths[95:80],
    // motion_flag[96], no_finger[97], zero fill [103:98]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // buzzer_on[0], tone_hz[12:1], fire_event[14:13], zero fill [15]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    step_en;
    logic    in_take;

    // The result stage moves whenever the output word is empty or being taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    sa_arb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sa_arb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .cfg     (cfg),
        .tick    (tick_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            tick_reg.now_ms         <= s_axis_tdata[31:0];
            tick_reg.epoch_s        <= s_axis_tdata[63:32];
            tick_reg.week_day       <= s_axis_tdata[66:64];
            tick_reg.minute_of_day  <= s_axis_tdata[77:67];
            tick_reg.session_active <= s_axis_tdata[78];
            tick_reg.light_or_awake <= s_axis_tdata[79];
            tick_reg.spo2_tenths    <= s_axis_tdata[95:80];
            tick_reg.motion_flag    <= s_axis_tdata[96];
            tick_reg.no_finger      <= s_axis_tdata[97];
        end
        if (step_en) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.fire_event, out_reg.tone_hz, out_reg.buzzer_on};

endmodule
